@@ src/dbzp_pkg.sv @@
// Shared types, codes and default constants for the DBZP code replica address generator.
`timescale 1ns / 1ps
`default_nettype none

package dbzp_pkg;

  // Default values of the top-level parameters.
  localparam int CODE_LENGTH_DEF = 1023;
  localparam int FRAC_BITS_DEF   = 30;
  localparam int MAX_PRN_DEF     = 63;

  // Fixed field widths.
  localparam int PRN_W   = 6;
  localparam int ADDR_W  = 16;
  localparam int BLK_W   = 12;
  localparam int STEP_W  = 32;
  localparam int SPB_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Step fixed-point format of the phase_step register (Q2.30).
  localparam int STEP_FRAC = 30;

  // Action codes of an input item.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPB        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 2'd2;

  // Register reset values.
  localparam logic [STEP_W-1:0] PHASE_STEP_RST = 32'h2000_0000;
  localparam logic [SPB_W-1:0]  SPB_RST        = 16'd1;
  localparam logic [BLK_W-1:0]  NUM_BLOCKS_RST = 12'd1;

  typedef struct packed {
    logic             action;
    logic [PRN_W-1:0] prn;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] code_address;
    logic              zero_pad;
    logic [BLK_W-1:0]  block_index;
    logic              last;
  } out_item_t;

  // Per-slot control handed to the sequencing units.
  typedef struct packed {
    logic advance;
    logic restart;
  } seq_ctrl_t;

  // Slot position reported by the slot counter.
  typedef struct packed {
    logic             pad;
    logic [BLK_W-1:0] blk;
    logic             seq_end;
  } slot_status_t;

endpackage

`default_nettype wire

@@ src/dbzp_phase_acc.sv @@
// Code phase accumulator: chip index modulo the code length plus a fractional phase.
`timescale 1ns / 1ps
`default_nettype none

module dbzp_phase_acc #(
  parameter int CODE_LENGTH = dbzp_pkg::CODE_LENGTH_DEF,
  parameter int FRAC_BITS   = dbzp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [dbzp_pkg::STEP_W-1:0]            phase_step,
  input  wire dbzp_pkg::seq_ctrl_t                    ctrl,
  output logic [((CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1)-1:0] chip_idx
);
  import dbzp_pkg::*;

  localparam int CHIP_W  = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int SSTEP_W = FRAC_BITS + 2;
  localparam int NEXT_W  = FRAC_BITS + 3;
  localparam int SUM_W   = CHIP_W + 3;
  localparam int SH_UP   = (FRAC_BITS >= STEP_FRAC) ? FRAC_BITS - STEP_FRAC : 0;
  localparam int SH_DN   = (FRAC_BITS < STEP_FRAC) ? STEP_FRAC - FRAC_BITS : 0;
  localparam logic [SUM_W-1:0] CL_S = SUM_W'(CODE_LENGTH);

  logic [CHIP_W-1:0]    chip_r, chip_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [SSTEP_W-1:0]   step_s;
  logic [NEXT_W-1:0]    next_sum;
  logic [SUM_W-1:0]     chip_sum;

  // Rescale the Q2.30 step into this accumulator's fraction width.
  always_comb begin
    if (FRAC_BITS >= STEP_FRAC) begin
      step_s = SSTEP_W'(phase_step) << SH_UP;
    end else begin
      step_s = SSTEP_W'(phase_step >> SH_DN);
    end
  end

  // The carry into the chip index is at most four, so a few conditional
  // subtractions bring the sum back below the code length.
  always_comb begin
    next_sum = NEXT_W'(frac_r) + NEXT_W'(step_s);
    chip_sum = SUM_W'(chip_r) + SUM_W'(next_sum[NEXT_W-1:FRAC_BITS]);
    for (int i = 0; i < 4; i++) begin
      if (chip_sum >= CL_S) begin
        chip_sum = chip_sum - CL_S;
      end
    end
    chip_nxt = CHIP_W'(chip_sum);
    frac_nxt = next_sum[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      chip_r <= '0;
      frac_r <= '0;
    end else if (ctrl.advance) begin
      chip_r <= chip_nxt;
      frac_r <= frac_nxt;
    end
  end

  assign chip_idx = chip_r;

endmodule

`default_nettype wire

@@ src/dbzp_slot_ctrl.sv @@
// Slot, half and block counters that frame the code and zero-pad halves of each block.
`timescale 1ns / 1ps
`default_nettype none

module dbzp_slot_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [dbzp_pkg::SPB_W-1:0]   samples_per_block,
  input  wire logic [dbzp_pkg::BLK_W-1:0]   num_blocks,
  input  wire dbzp_pkg::seq_ctrl_t          ctrl,
  output dbzp_pkg::slot_status_t            status
);
  import dbzp_pkg::*;

  logic [SPB_W-1:0] slot_r, slot_inc, spb_eff;
  logic [BLK_W-1:0] blk_r, blk_inc, nb_eff;
  logic             pad_r;
  logic             half_end, seq_end;

  always_comb begin
    spb_eff  = (samples_per_block == '0) ? SPB_W'(1) : samples_per_block;
    nb_eff   = (num_blocks == '0) ? BLK_W'(1) : num_blocks;
    slot_inc = slot_r + SPB_W'(1);
    blk_inc  = blk_r + BLK_W'(1);
    // A counter already past a lowered limit ends its half or block at once.
    half_end = (slot_inc >= spb_eff) || (slot_inc == '0);
    seq_end  = half_end && pad_r && ((blk_inc >= nb_eff) || (blk_inc == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      slot_r <= '0;
      pad_r  <= 1'b0;
      blk_r  <= '0;
    end else if (ctrl.advance) begin
      if (seq_end) begin
        slot_r <= '0;
        pad_r  <= 1'b0;
        blk_r  <= '0;
      end else if (half_end) begin
        slot_r <= '0;
        pad_r  <= !pad_r;
        if (pad_r) begin
          blk_r <= blk_inc;
        end
      end else begin
        slot_r <= slot_inc;
      end
    end
  end

  assign status.pad     = pad_r;
  assign status.blk     = blk_r;
  assign status.seq_end = seq_end;

endmodule

`default_nettype wire

@@ src/dbzp_code_replica_address_gen_core.sv @@
// Top level of the DBZP code replica address generator: ports, registers and output stage.
`timescale 1ns / 1ps
`default_nettype none

// This block produces read addresses into a C/A chip table for double-block
// zero-padding acquisition. A start transfer (action 0) selects the row of a
// satellite, whose base is (prn - 1) * CODE_LENGTH, and restarts the sequence;
// it yields no result. Each step transfer (action 1) then yields one slot: a
// block is samples_per_block code slots, each reading chip floor(n * step)
// mod CODE_LENGTH of the row, followed by as many zero-pad slots with address
// zero. The final slot of the last block carries last, after which the
// sequence starts again from phase zero. Steps before the first start are
// dropped. A prn of zero counts as 1 and one above MAX_PRN as MAX_PRN; zero
// block sizes or counts count as 1. The block takes one transfer per clock
// cycle while out_ready stays high: an input register and a result register
// frame the logic, whose longest path is the phase add followed by the
// short modulo reduction of the chip index. An accepted item waits in the
// input register; its result is then loaded into the result register and
// presented from there. While a result waits for out_ready, one more input
// transfer is still taken into the input register. The configuration port
// is always ready; registers should be written only while the block is idle.
module dbzp_code_replica_address_gen_core #(
  parameter int CODE_LENGTH = dbzp_pkg::CODE_LENGTH_DEF,
  parameter int FRAC_BITS   = dbzp_pkg::FRAC_BITS_DEF,
  parameter int MAX_PRN     = dbzp_pkg::MAX_PRN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire dbzp_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output dbzp_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dbzp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dbzp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dbzp_pkg::*;

  localparam int CHIP_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int PROD_W = PRN_W + 12;

  // Configuration registers.
  logic [STEP_W-1:0] phase_step_r;
  logic [SPB_W-1:0]  spb_r;
  logic [BLK_W-1:0]  num_blocks_r;

  // Input register, sequence state and result register.
  in_item_t          in_item_r;
  logic              s1_valid_r;
  logic              active_r;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic              out_valid_r;

  logic              process, start_en, step_en;
  logic [PRN_W-1:0]  prn_eff;
  logic [CHIP_W-1:0] chip_idx;
  seq_ctrl_t         slot_ctrl, phase_ctrl;
  slot_status_t      status;

  // The item in the input register is worked off whenever the result
  // register is free or is being emptied in the same cycle.
  assign process  = s1_valid_r && (!out_valid_r || out_ready);
  assign start_en = process && (in_item_r.action == ACT_START);
  assign step_en  = process && (in_item_r.action == ACT_STEP) && active_r;
  assign in_ready = !s1_valid_r || process;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      spb_r        <= SPB_RST;
      num_blocks_r <= NUM_BLOCKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: phase_step_r <= cfg_data;
        CFG_SPB:        spb_r        <= cfg_data[SPB_W-1:0];
        CFG_NUM_BLOCKS: num_blocks_r <= cfg_data[BLK_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencing units. The phase only moves on code slots, and it is cleared
  // on a start and after the final slot of a sequence.
  assign slot_ctrl.advance  = step_en;
  assign slot_ctrl.restart  = start_en;
  assign phase_ctrl.advance = step_en && !status.pad;
  assign phase_ctrl.restart = start_en || (step_en && status.seq_end);

  dbzp_slot_ctrl u_slot_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .samples_per_block (spb_r),
    .num_blocks        (num_blocks_r),
    .ctrl              (slot_ctrl),
    .status            (status)
  );

  dbzp_phase_acc #(
    .CODE_LENGTH (CODE_LENGTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_phase_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_step (phase_step_r),
    .ctrl       (phase_ctrl),
    .chip_idx   (chip_idx)
  );

  // Row base of the selected satellite, with the prn clamped into range.
  always_comb begin
    prn_eff = in_item_r.prn;
    if (prn_eff == '0) begin
      prn_eff = PRN_W'(1);
    end
    if (prn_eff > PRN_W'(MAX_PRN)) begin
      prn_eff = PRN_W'(MAX_PRN);
    end
    row_base_nxt = ADDR_W'(PROD_W'(prn_eff - PRN_W'(1)) * PROD_W'(CODE_LENGTH));
  end

  always_comb begin
    out_item_nxt.code_address = status.pad ? '0 : ADDR_W'(row_base_r + ADDR_W'(chip_idx));
    out_item_nxt.zero_pad     = status.pad;
    out_item_nxt.block_index  = status.blk;
    out_item_nxt.last         = status.seq_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      row_base_r  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (process) begin
        s1_valid_r <= 1'b0;
      end
      if (start_en) begin
        active_r   <= 1'b1;
        row_base_r <= row_base_nxt;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (step_en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A pad slot always reads address zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.zero_pad |-> out_item_r.code_address == '0)
    else $error("pad slot carries a nonzero address");

  // The final slot of a sequence always falls in a pad half.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.last |-> out_item_r.zero_pad)
    else $error("last flag on a code slot");

  // No result appears before a satellite has been started.
  assert property (@(posedge clk) disable iff (!rst_n)
    !active_r && !out_valid_r |=> !out_valid_r)
    else $error("result produced while inactive");

  // An item held in the input register is not lost or altered while stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !process |=> s1_valid_r && $stable(in_item_r))
    else $error("stalled input item lost");

endmodule

`default_nettype wire

@@ dv/dbzp_code_replica_address_gen_core_tb.sv @@
// Self-checking testbench for the DBZP code replica address generator core.
`timescale 1ns / 1ps

// The stimulus process fills a queue of input items phase by phase and writes
// the registers in between, while the block is idle. A clocked driver offers
// the queued items on the input channel. A clocked monitor takes the results
// and compares them with the predictions. The predictor runs at the edge that
// accepts each input transfer and keeps its own copy of the registers and of
// the sequence state. Both sides idle at random in several phases. In one
// phase the receiver holds off for a long stretch so that the block fills up
// and stalls its input. At each phase boundary the sender pauses until every
// expected result has come. A watchdog ends the run when nothing moves for
// too long.
module dbzp_code_replica_address_gen_core_tb;
  import dbzp_pkg::*;

  localparam int CODE_LEN     = CODE_LENGTH_DEF;
  localparam int FRAC_W       = FRAC_BITS_DEF;
  localparam int PRN_MAX      = MAX_PRN_DEF;
  // Settling margin after the last expected result, for a start still in flight.
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 4000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PHASE_STEP;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  dbzp_code_replica_address_gen_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Items waiting to be offered, and slots predicted but not yet received.
  in_item_t  pending_items[$];
  out_item_t slot_q[$];

  int err_count      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // The stimulus process bumps hold_req; the monitor serves each request once.
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // Register copies, starting from their reset values.
  logic [STEP_W-1:0] step_reg = PHASE_STEP_RST;
  logic [SPB_W-1:0]  spb_reg  = SPB_RST;
  logic [BLK_W-1:0]  nblk_reg = NUM_BLOCKS_RST;

  // Sequence state of the predictor. The phase is split into the chip index,
  // kept below the code length, and the fraction below it.
  logic [ADDR_W-1:0] row_base_p = '0;
  logic [63:0]       chip_p     = '0;
  logic [63:0]       frac_p     = '0;
  logic [SPB_W-1:0]  slot_p     = '0;
  logic              pad_p      = 1'b0;
  logic [BLK_W-1:0]  blk_p      = '0;
  logic              active_p   = 1'b0;

  function automatic void restart_seq();
    chip_p = '0;
    frac_p = '0;
    slot_p = '0;
    pad_p  = 1'b0;
    blk_p  = '0;
  endfunction

  // Works out the slot that one accepted item yields. Returns 0 when the item
  // yields nothing: a start, or a step before any satellite was selected.
  function automatic bit predict_slot(input in_item_t it, output out_item_t res);
    int               prn_num;
    logic [63:0]      step_acc;
    logic [63:0]      next;
    logic [SPB_W-1:0] spb_eff;
    logic [BLK_W-1:0] nblk_eff;
    res = '0;
    if (it.action == ACT_START) begin
      // A prn of zero selects the first row; ones above PRN_MAX saturate.
      prn_num = (it.prn == '0) ? 1 : int'(it.prn);
      if (prn_num > PRN_MAX) prn_num = PRN_MAX;
      row_base_p = ADDR_W'((prn_num - 1) * CODE_LEN);
      restart_seq();
      active_p = 1'b1;
      return 1'b0;
    end
    if (!active_p) return 1'b0;
    // Zero sizes count as one.
    spb_eff  = (spb_reg == '0) ? SPB_W'(1) : spb_reg;
    nblk_eff = (nblk_reg == '0) ? BLK_W'(1) : nblk_reg;
    if (FRAC_W >= STEP_FRAC) step_acc = 64'(step_reg) << (FRAC_W - STEP_FRAC);
    else step_acc = 64'(step_reg) >> (STEP_FRAC - FRAC_W);
    res.zero_pad    = pad_p;
    res.block_index = blk_p;
    if (!pad_p) begin
      // The phase moves only on code slots; the address uses the phase before the step.
      res.code_address = ADDR_W'(64'(row_base_p) + chip_p);
      next   = frac_p + step_acc;
      chip_p = (chip_p + (next >> FRAC_W)) % 64'(CODE_LEN);
      frac_p = next & ((64'd1 << FRAC_W) - 64'd1);
    end
    // A counter already past a freshly lowered limit ends its half at once.
    slot_p = slot_p + 1'b1;
    if (slot_p >= spb_eff || slot_p == '0) begin
      slot_p = '0;
      if (!pad_p) begin
        pad_p = 1'b1;
      end else begin
        pad_p = 1'b0;
        blk_p = blk_p + 1'b1;
        if (blk_p >= nblk_eff || blk_p == '0) begin
          res.last = 1'b1;
          restart_seq();
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Driver: predicts each accepted item, then offers the next one from the
  // queue unless this cycle is chosen to idle. Valid stays up until accepted.
  always @(posedge clk) begin : item_driver
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (predict_slot(in_item, res)) slot_q.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each received slot against the oldest prediction and
  // decides out_ready for the next cycle, including the long hold-off.
  always @(posedge clk) begin : slot_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (slot_q.size() == 0) begin
          $error("unexpected slot: address %0d pad %0b block %0d last %0b",
                 out_item.code_address, out_item.zero_pad, out_item.block_index,
                 out_item.last);
          err_count++;
        end else begin
          want = slot_q.pop_front();
          compare_field("code_address", 32'(want.code_address),
                        32'(out_item.code_address));
          compare_field("zero_pad", 32'(want.zero_pad), 32'(out_item.zero_pad));
          compare_field("block_index", 32'(want.block_index),
                        32'(out_item.block_index));
          compare_field("last", 32'(want.last), 32'(out_item.last));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic act, input logic [PRN_W-1:0] prn);
    in_item_t it;
    it.action = act;
    it.prn    = prn;
    pending_items.push_back(it);
  endtask

  // Mostly steps with random content; now and then a start that cuts the
  // running sequence short and selects a random satellite.
  task automatic add_traffic(input int count, input int start_pct);
    repeat (count) begin
      if ($urandom_range(99) < start_pct) push_item(ACT_START, PRN_W'($urandom));
      else push_item(ACT_STEP, PRN_W'($urandom));
    end
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Waits until every item is accepted and every predicted slot has arrived,
  // then gives a start still in flight time to settle.
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || slot_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PHASE_STEP: step_reg = data;
      CFG_SPB:        spb_reg  = data[SPB_W-1:0];
      CFG_NUM_BLOCKS: nblk_reg = data[BLK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [STEP_W-1:0] step, input logic [SPB_W-1:0] spb,
                           input logic [BLK_W-1:0] nblk);
    write_reg(CFG_PHASE_STEP, CFG_DATA_W'(step));
    write_reg(CFG_SPB, CFG_DATA_W'(spb));
    write_reg(CFG_NUM_BLOCKS, CFG_DATA_W'(nblk));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset registers. Steps before any start are dropped.
    set_idle(0, 0);
    push_item(ACT_STEP, 6'd5);
    push_item(ACT_STEP, 6'd63);
    // A prn of zero reads the row of the first satellite. With one slot per
    // half and one block, every second step closes the sequence.
    push_item(ACT_START, 6'd0);
    repeat (4) push_item(ACT_STEP, PRN_W'($urandom));
    // The highest satellite row.
    push_item(ACT_START, 6'd63);
    repeat (2) push_item(ACT_STEP, 6'd0);
    wait_quiet();

    // Largest step, so the chip index wraps past the code length quickly.
    // Two blocks of three code and three pad slots make one full sequence.
    load_regs(32'hFFFF_FFFF, 16'd3, 12'd2);
    push_item(ACT_START, 6'd37);
    repeat (12) push_item(ACT_STEP, 6'd26);
    wait_quiet();

    // Zero block size and count behave as one.
    set_idle(0, 0);
    load_regs(STEP_W'($urandom), 16'd0, 12'd0);
    add_traffic(100, 5);
    wait_quiet();

    // Zero step keeps the address at the row base; the sender idles.
    set_idle(64, 0);
    load_regs(32'd0, 16'd5, 12'd3);
    add_traffic(150, 4);
    wait_quiet();

    // The receiver stalls, and first holds off long enough that the block
    // fills and refuses input while the sender keeps offering.
    set_idle(0, 64);
    load_regs(STEP_W'($urandom), 16'd2, 12'd4095);
    add_traffic(150, 3);
    hold_req++;
    wait_quiet();

    // Both sides idle; midway the sender pauses until all results are in.
    set_idle(32, 32);
    load_regs(STEP_W'($urandom_range(32'hFFFF_FFFF, 32'hF000_0000)), 16'd7, 12'd2);
    add_traffic(75, 4);
    wait_quiet();
    add_traffic(75, 4);
    wait_quiet();

    // Largest sizes: only a short run into the first block.
    set_idle(0, 0);
    load_regs(STEP_W'($urandom), 16'hFFFF, 12'd4095);
    push_item(ACT_START, PRN_W'($urandom));
    repeat (60) push_item(ACT_STEP, PRN_W'($urandom));
    wait_quiet();

    // Shrink the block while the slot counter is far past the new size, with
    // no new start: the current half has to end on the next slot.
    set_idle(32, 32);
    load_regs(STEP_W'($urandom), 16'd3, 12'd1);
    add_traffic(40, 3);
    wait_quiet();

    // Random small settings under random idling.
    repeat (4) begin
      case ($urandom_range(3))
        0: set_idle(0, 0);
        1: set_idle(64, 0);
        2: set_idle(0, 64);
        default: set_idle(32, 32);
      endcase
      load_regs(STEP_W'($urandom), SPB_W'($urandom_range(6, 1)), BLK_W'($urandom_range(5, 1)));
      add_traffic(45, 4);
      wait_quiet();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ dbzp_code_replica_address_gen_core.f @@
src/dbzp_pkg.sv
src/dbzp_phase_acc.sv
src/dbzp_slot_ctrl.sv
src/dbzp_code_replica_address_gen_core.sv
dv/dbzp_code_replica_address_gen_core_tb.sv
